// File: hdl/triangle_face_normal_defines.svh
// ----------------------------------------------------------------------------
// triangle_face_normal assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_FACE_NORMAL_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_DEFINES_SVH

// same-cycle implication
`define TFN_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TFN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Types and fixed constants shared by the face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int NUM_AXES = 3;
  localparam int MAG_W    = 31;  // scaled cross magnitude width
  localparam int SQ_W     = 64;  // sum of squares width
  localparam int ROOT_W   = 32;  // integer square root width
  localparam int OUT_W    = 16;  // normal component width

  typedef struct packed {
    logic en;   // pipeline advance
    logic vld;  // item present at unit input
  } stg_ctl_t;

endpackage

// File: hdl/tfn_sqrt.sv
// ----------------------------------------------------------------------------
// tfn_sqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module tfn_sqrt #(
  parameter int SBW = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tfn_pkg::stg_ctl_t         ctl_i,
  input  logic [tfn_pkg::SQ_W-1:0]  rad_i,
  input  logic [SBW-1:0]            sb_i,
  output logic                      vld_o,
  output logic [tfn_pkg::ROOT_W-1:0] root_o,
  output logic [SBW-1:0]            sb_o
);
  import tfn_pkg::*;

  localparam int NST = ROOT_W;
  localparam int RW  = ROOT_W + 3;

  logic [SQ_W-1:0]   x_s    [0:NST];
  logic [RW-1:0]     rem_s  [0:NST];
  logic [ROOT_W-1:0] root_s [0:NST];
  logic              vld_s  [0:NST];
  logic [SBW-1:0]    sb_s   [0:NST];

  assign x_s[0]    = rad_i;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign vld_s[0]  = ctl_i.vld;
  assign sb_s[0]   = sb_i;

  for (genvar k = 0; k < NST; k++) begin : g_stg
    logic [RW-1:0]     sh, trial, dif;
    logic              ge;
    logic              vld_q;
    logic [SQ_W-1:0]   x_q;
    logic [RW-1:0]     rem_q;
    logic [ROOT_W-1:0] root_q;
    logic [SBW-1:0]    sb_q;

    always_comb begin
      sh    = {rem_s[k][RW-3:0], x_s[k][SQ_W-1 -: 2]};
      trial = {1'b0, root_s[k], 2'b01};
      dif   = sh - trial;
      ge    = (sh >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        x_q    <= {x_s[k][SQ_W-3:0], 2'b00};
        rem_q  <= ge ? dif : sh;
        root_q <= {root_s[k][ROOT_W-2:0], ge};
        sb_q   <= sb_s[k];
      end
    end

    assign x_s[k+1]    = x_q;
    assign rem_s[k+1]  = rem_q;
    assign root_s[k+1] = root_q;
    assign vld_s[k+1]  = vld_q;
    assign sb_s[k+1]   = sb_q;
  end

  assign vld_o  = vld_s[NST];
  assign root_o = root_s[NST];
  assign sb_o   = sb_s[NST];

endmodule

// File: hdl/tfn_div.sv
// ----------------------------------------------------------------------------
// tfn_div
// Three-lane pipelined restoring divider by a shared divisor, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module tfn_div #(
  parameter int FRAC_BITS = 14,
  parameter int SBW       = 1
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  tfn_pkg::stg_ctl_t                               ctl_i,
  input  logic [tfn_pkg::NUM_AXES-1:0][FRAC_BITS+31:0]    num_i,
  input  logic [tfn_pkg::ROOT_W-1:0]                      den_i,
  input  logic [SBW-1:0]                                  sb_i,
  output logic                                            vld_o,
  output logic [tfn_pkg::NUM_AXES-1:0][FRAC_BITS:0]       quo_o,
  output logic [SBW-1:0]                                  sb_o
);
  import tfn_pkg::*;

  localparam int NW = FRAC_BITS + 32;
  localparam int QB = FRAC_BITS + 1;

  logic [NUM_AXES-1:0][NW-1:0]     n_s   [0:QB];
  logic [NUM_AXES-1:0][ROOT_W-1:0] rem_s [0:QB];
  logic [NUM_AXES-1:0][QB-1:0]     quo_s [0:QB];
  logic [ROOT_W-1:0]               d_s   [0:QB];
  logic                            vld_s [0:QB];
  logic [SBW-1:0]                  sb_s  [0:QB];

  // quotient fits QB bits, so the high part already sits below the divisor
  always_comb begin
    for (int l = 0; l < NUM_AXES; l++) begin
      rem_s[0][l] = {1'b0, num_i[l][NW-1:QB]};
    end
  end
  assign n_s[0]   = num_i;
  assign quo_s[0] = '0;
  assign d_s[0]   = den_i;
  assign vld_s[0] = ctl_i.vld;
  assign sb_s[0]  = sb_i;

  for (genvar k = 0; k < QB; k++) begin : g_stg
    logic [NUM_AXES-1:0][ROOT_W-1:0] rem_d;
    logic [NUM_AXES-1:0][QB-1:0]     quo_d;
    logic                            vld_q;
    logic [NUM_AXES-1:0][NW-1:0]     n_q;
    logic [NUM_AXES-1:0][ROOT_W-1:0] rem_q;
    logic [NUM_AXES-1:0][QB-1:0]     quo_q;
    logic [ROOT_W-1:0]               d_q;
    logic [SBW-1:0]                  sb_q;

    always_comb begin
      logic [ROOT_W:0] t;
      logic [ROOT_W:0] dif;
      logic            ge;
      for (int l = 0; l < NUM_AXES; l++) begin
        t        = {rem_s[k][l], n_s[k][l][QB-1-k]};
        dif      = t - {1'b0, d_s[k]};
        ge       = (t >= {1'b0, d_s[k]});
        rem_d[l] = ge ? dif[ROOT_W-1:0] : t[ROOT_W-1:0];
        quo_d[l] = {quo_s[k][l][QB-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        n_q   <= n_s[k];
        rem_q <= rem_d;
        quo_q <= quo_d;
        d_q   <= d_s[k];
        sb_q  <= sb_s[k];
      end
    end

    assign n_s[k+1]   = n_q;
    assign rem_s[k+1] = rem_q;
    assign quo_s[k+1] = quo_q;
    assign d_s[k+1]   = d_q;
    assign vld_s[k+1] = vld_q;
    assign sb_s[k+1]  = sb_q;
  end

  assign vld_o = vld_s[QB];
  assign quo_o = quo_s[QB];
  assign sb_o  = sb_s[QB];

endmodule

// File: hdl/triangle_face_normal.sv
// ----------------------------------------------------------------------------
// triangle_face_normal
// Flat unit face normal of a triangle given as three fixed-point vertices.
// ----------------------------------------------------------------------------
// Takes one triangle per clock while the output is not stalled, and returns
// one normal per triangle, in order. The pipe holds nine stages for edges,
// cross product, block scaling and sum of squares, a 32-stage bit-per-stage
// square root, a rounding-offset stage, a three-lane divider giving one
// quotient bit per stage, and the output register. The whole pipe advances
// whenever the output register is empty or being taken, so a stall at the
// output holds every item in place. A triangle whose cross product is zero
// returns a zero normal with tuser set.
`include "triangle_face_normal_defines.svh"

module triangle_face_normal #(
  parameter int COORD_WIDTH      = 24,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, zero pad
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]            s_axis_tdata,
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // normal_x, normal_y, normal_z
  output logic [3*tfn_pkg::OUT_W-1:0]                   m_axis_tdata,
  // degenerate
  output logic                                          m_axis_tuser
);
  import tfn_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int F   = NORMAL_FRAC_BITS;
  localparam int ES  = (CW > 30) ? CW - 30 : 0;
  localparam int EW  = CW + 1 - ES;
  localparam int PRW = 2 * EW;
  localparam int PW  = PRW + 1;
  localparam int MGW = PRW;
  localparam int XW  = (MGW > MAG_W) ? MGW : MAG_W;
  localparam int SHW = $clog2(MGW + 1);
  localparam int QB  = F + 1;
  localparam int NW  = F + 32;
  localparam int SQB = 3 * MAG_W + 4;
  localparam int DSB = 4;

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic [8:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[7:0], s_axis_tvalid};
    end
  end

  // stage 1: edges
  logic signed [CW-1:0] vin [9];
  logic signed [EW-1:0] e1_d [3], e2_d [3], e1_q [3], e2_q [3];

  always_comb begin
    logic signed [CW:0] d1, d2;
    for (int i = 0; i < 9; i++) begin
      vin[i] = signed'(s_axis_tdata[i*CW +: CW]);
    end
    for (int i = 0; i < 3; i++) begin
      d1      = (CW+1)'(vin[3+i]) - (CW+1)'(vin[i]);
      d2      = (CW+1)'(vin[6+i]) - (CW+1)'(vin[i]);
      e1_d[i] = EW'(d1 >>> ES);
      e2_d[i] = EW'(d2 >>> ES);
    end
  end

  // stages 2..9 payload
  logic signed [PRW-1:0] pr_q [6];
  logic signed [PW-1:0]  c_q [3];
  logic [MGW-1:0]        mag4_q [3], mag5_q [3], mag6_q [3];
  logic [2:0]            sg4_q, sg5_q, sg6_q, sg7_q, sg8_q, sg9_q;
  logic                  dg4_q, dg5_q, dg6_q, dg7_q, dg8_q, dg9_q;
  logic [MGW-1:0]        orv_q;
  logic [SHW-1:0]        sh_q;
  logic [MAG_W-1:0]      m7_q [3], m8_q [3], m9_q [3];
  logic [2*MAG_W-1:0]    sqr_q [3];
  logic [SQ_W-1:0]       sum_q;

  logic [SHW-1:0] bl, sh_d;
  always_comb begin
    bl = '0;
    for (int i = 0; i < MGW; i++) begin
      if (orv_q[i]) bl = SHW'(i + 1);
    end
    sh_d = (bl > SHW'(MAG_W)) ? bl - SHW'(MAG_W) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= e1_d[i];
        e2_q[i] <= e2_d[i];
      end
      // yz, zy, zx, xz, xy, yx
      pr_q[0] <= PRW'(e1_q[1]) * PRW'(e2_q[2]);
      pr_q[1] <= PRW'(e1_q[2]) * PRW'(e2_q[1]);
      pr_q[2] <= PRW'(e1_q[2]) * PRW'(e2_q[0]);
      pr_q[3] <= PRW'(e1_q[0]) * PRW'(e2_q[2]);
      pr_q[4] <= PRW'(e1_q[0]) * PRW'(e2_q[1]);
      pr_q[5] <= PRW'(e1_q[1]) * PRW'(e2_q[0]);
      for (int i = 0; i < 3; i++) begin
        c_q[i] <= PW'(pr_q[2*i]) - PW'(pr_q[2*i+1]);
      end
      for (int i = 0; i < 3; i++) begin
        mag4_q[i] <= MGW'(c_q[i][PW-1] ? -c_q[i] : c_q[i]);
        sg4_q[i]  <= c_q[i][PW-1];
      end
      dg4_q <= (c_q[0] == '0) && (c_q[1] == '0) && (c_q[2] == '0);
      // block scaling: leading one of the largest magnitude
      mag5_q <= mag4_q;
      sg5_q  <= sg4_q;
      dg5_q  <= dg4_q;
      orv_q  <= mag4_q[0] | mag4_q[1] | mag4_q[2];
      mag6_q <= mag5_q;
      sg6_q  <= sg5_q;
      dg6_q  <= dg5_q;
      sh_q   <= sh_d;
      for (int i = 0; i < 3; i++) begin
        m7_q[i] <= MAG_W'(XW'(mag6_q[i]) >> sh_q);
      end
      sg7_q <= sg6_q;
      dg7_q <= dg6_q;
      for (int i = 0; i < 3; i++) begin
        sqr_q[i] <= (2*MAG_W)'(m7_q[i]) * (2*MAG_W)'(m7_q[i]);
      end
      m8_q  <= m7_q;
      sg8_q <= sg7_q;
      dg8_q <= dg7_q;
      sum_q <= SQ_W'(sqr_q[0]) + SQ_W'(sqr_q[1]) + SQ_W'(sqr_q[2]);
      m9_q  <= m8_q;
      sg9_q <= sg8_q;
      dg9_q <= dg8_q;
    end
  end

  // square root
  stg_ctl_t          sq_ctl;
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  logic [SQB-1:0]    sq_sb_in, sq_sb;

  assign sq_ctl   = '{en: en, vld: vld_q[8]};
  assign sq_sb_in = {dg9_q, sg9_q, m9_q[2], m9_q[1], m9_q[0]};

  tfn_sqrt #(.SBW(SQB)) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sq_ctl),
    .rad_i  (sum_q),
    .sb_i   (sq_sb_in),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .sb_o   (sq_sb)
  );

  // rounding offset and numerators
  logic                              pre_vld_q;
  logic [NUM_AXES-1:0][NW-1:0]       pre_num_q;
  logic [ROOT_W-1:0]                 pre_den_q;
  logic [DSB-1:0]                    pre_sb_q;
  logic [ROOT_W-1:0]                 rfix;

  assign rfix = (sq_root == '0) ? ROOT_W'(1) : sq_root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= 1'b0;
    end else if (en) begin
      pre_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        pre_num_q[i] <= {1'b0, sq_sb[i*MAG_W +: MAG_W], F'(0)} + NW'(rfix >> 1);
      end
      pre_den_q <= rfix;
      pre_sb_q  <= sq_sb[SQB-1 -: DSB];
    end
  end

  // division
  stg_ctl_t                    dv_ctl;
  logic                        dv_vld;
  logic [NUM_AXES-1:0][QB-1:0] dv_quo;
  logic [DSB-1:0]              dv_sb;

  assign dv_ctl = '{en: en, vld: pre_vld_q};

  tfn_div #(.FRAC_BITS(F), .SBW(DSB)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dv_ctl),
    .num_i  (pre_num_q),
    .den_i  (pre_den_q),
    .sb_i   (pre_sb_q),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .sb_o   (dv_sb)
  );

  // clamp, sign and output register
  logic [3*OUT_W-1:0] out_d;
  always_comb begin
    logic [QB-1:0]       q;
    logic [QB:0]         sq;
    logic [QB+OUT_W-1:0] wide;
    for (int i = 0; i < NUM_AXES; i++) begin
      q    = (dv_quo[i] > {1'b1, F'(0)}) ? {1'b1, F'(0)} : dv_quo[i];
      sq   = dv_sb[i] ? -{1'b0, q} : {1'b0, q};
      wide = {{(OUT_W-1){sq[QB]}}, sq};
      out_d[i*OUT_W +: OUT_W] = dv_sb[DSB-1] ? '0 : wide[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= out_d;
      m_axis_tuser <= dv_sb[DSB-1];
    end
  end

  `TFN_ASSERT(a_deg_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "degenerate item with nonzero normal")
  `TFN_ASSERT(a_root_nz, sq_vld && !sq_sb[SQB-1], sq_root != '0, "zero root for a nondegenerate item")
  `TFN_ASSERT_NEXT(a_nz_normal, en && dv_vld && !dv_sb[DSB-1] && (F <= 14), out_d != '0 || !m_axis_tvalid || m_axis_tdata != '0, "nondegenerate item gave zero normal")

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Face normal check: random and corner-case triangles streamed through the
// block under varying source/sink throttling, normals predicted and compared.
// ----------------------------------------------------------------------------

class normal_scoreboard;
  typedef struct packed {
    logic [15:0] nx, ny, nz;
    logic        degen;
  } normal_t;

  normal_t pending[$];
  int      errors;
  int      checked;
  int      degen_seen;

  function longint unsigned isqrt(longint unsigned x);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // default widths: no edge prescale
  function normal_t face_normal(logic [215:0] tri_bits);
    longint          p[9];
    longint          e1[3], e2[3], c[3];
    longint unsigned mag[3], m[3], mx, sum, r, q;
    int              s;
    normal_t         n;
    logic [15:0]     o[3];
    for (int i = 0; i < 9; i++) p[i] = longint'($signed(tri_bits[i*24 +: 24]));
    for (int i = 0; i < 3; i++) begin
      e1[i] = p[3+i] - p[i];
      e2[i] = p[6+i] - p[i];
    end
    c[0] = e1[1]*e2[2] - e1[2]*e2[1];
    c[1] = e1[2]*e2[0] - e1[0]*e2[2];
    c[2] = e1[0]*e2[1] - e1[1]*e2[0];
    if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
      n = '0;
      n.degen = 1'b1;
      return n;
    end
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = c[i] < 0 ? -c[i] : c[i];
      if (mag[i] > mx) mx = mag[i];
    end
    s = 0;
    while ((mx >> s) >= (64'd1 << 31)) s++;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag[i] >> s;
      sum  = sum + m[i]*m[i];
    end
    r = isqrt(sum);
    if (r == 0) r = 1;
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 14) + (r >> 1)) / r;
      if (q > (64'd1 << 14)) q = 64'd1 << 14;
      o[i] = c[i] < 0 ? 16'(-q) : 16'(q);
    end
    n.nx = o[0]; n.ny = o[1]; n.nz = o[2]; n.degen = 1'b0;
    return n;
  endfunction

  function void note_triangle(logic [215:0] tri_bits);
    pending.push_back(face_normal(tri_bits));
  endfunction

  function void check_normal(logic [47:0] data, logic degen);
    normal_t want, got;
    got = {data[15:0], data[31:16], data[47:32], degen};
    checked++;
    if (degen) degen_seen++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected normal %h degen %b", data, degen);
      return;
    end
    want = pending.pop_front();
    if (want != got) begin
      errors++;
      if (errors <= 10)
        $display("normal mismatch: exp x=%h y=%h z=%h d=%b  got x=%h y=%h z=%h d=%b",
                 want.nx, want.ny, want.nz, want.degen,
                 got.nx, got.ny, got.nz, got.degen);
    end
  endfunction
endclass

module tb_top;
  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [215:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic         m_axis_tuser;

  normal_scoreboard sb = new();
  int  src_idle_pct, snk_idle_pct;
  int  hold_off;
  int  cycles;
  int  sent;

  triangle_face_normal dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_normal(m_axis_tdata, m_axis_tuser);

  // sink throttle; hold_off forces a long stall
  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else if (hold_off > 0) begin
      m_axis_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($signed($urandom_range(64)) - 32);
      default: return 24'($urandom);
    endcase
  endfunction

  // valid stays up between back-to-back items; idle cycles drop it
  task automatic send_triangle(logic [215:0] tri_bits);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= tri_bits;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_triangle(tri_bits);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic send_random(int count);
    logic [215:0] t;
    for (int k = 0; k < count; k++) begin
      for (int i = 0; i < 9; i++) t[i*24 +: 24] = rand_coord();
      // some collinear or coincident vertices to hit the degenerate path
      if ($urandom_range(19) == 0) t[144 +: 72] = t[72 +: 72];
      if ($urandom_range(19) == 0) t[72 +: 72] = t[0 +: 72];
      send_triangle(t);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  initial begin
    logic [23:0] mx, mn;
    cycles = 0;
    hold_off = 0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    mx = 24'h7FFFFF;
    mn = 24'h800000;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: unit axes, extremes, degenerate cases
    send_triangle('0);
    send_triangle({24'd0, 24'h001000, 24'd0, 24'd0, 24'd0, 24'h001000, 72'd0});
    send_triangle({24'h001000, 24'd0, 24'd0, 24'd0, 24'd0, 24'h001000, 72'd0});
    send_triangle({24'd0, 24'd0, 24'h001000, 24'h001000, 24'd0, 24'd0, 72'd0});
    send_triangle({mx, mx, mx, mn, mn, mn, mn, mx, mn});
    send_triangle({mn, mn, mx, mx, mx, mn, mx, mn, mx});
    send_triangle({mx, mx, mx, mx, mx, mx, mx, mx, mx});
    send_triangle({mn, mn, mn, mx, mx, mx, mn, mn, mn});
    send_triangle({mx, mn, mx, mn, mx, mn, 72'd0});
    send_triangle({24'd2, 24'd2, 24'd2, 24'd1, 24'd1, 24'd1, 72'd0});
    send_triangle({mx, 24'd0, 24'd0, 24'd0, mx, 24'd0, 24'd0, 24'd0, mx});
    send_triangle({24'd1, 24'd0, 24'd0, 24'd0, 24'd1, 24'd0, 72'd0});
    send_triangle({mn, 24'd1, 24'd0, 24'd1, mx, mn, 24'd3, mn, 24'd1});
    send_triangle({24'hFFFFFF, 24'd1, 24'd0, 24'd0, 24'd1, 24'hFFFFFF, 72'd0});
    drain();

    src_idle_pct = 8;  snk_idle_pct = 60;
    send_random(550);
    src_idle_pct = 60; snk_idle_pct = 8;
    send_random(550);
    drain();  // sender waits for every result
    src_idle_pct = 0;  snk_idle_pct = 0;
    hold_off = 300;    // long sink stall fills the pipe
    send_random(550);
    drain();

    $display("triangles sent %0d, normals checked %0d, degenerate %0d",
             sent, sb.checked, sb.degen_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("errors %0d, left over %0d", sb.errors, sb.pending.size());
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+hdl
hdl/tfn_pkg.sv
hdl/tfn_sqrt.sv
hdl/tfn_div.sv
hdl/triangle_face_normal.sv
verif/tb_top.sv
